// ----- rtl/assert_macros.svh -----
// Assertion helper macros for the sorted list block.
// Self-contained; taken in by the top level through `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/slid_pkg.sv -----
// Shared types and constants for the sorted list insert/delete block.
// No dependencies; used by slid_cell, slid_ctrl and the top level.
package slid_pkg;

  localparam int VAL_W  = 14;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 6;
  localparam int IN_W   = 16;
  localparam int OUT_W  = 32;

  localparam logic [FUNC_W-1:0] OP_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;
  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [VAL_W-1:0] VALUE_MIN = 14'd1;
  localparam logic [VAL_W-1:0] VALUE_MAX = 14'd9999;

  // Per-cycle command to the cell chain.
  typedef struct packed {
    logic pop;   // shift every cell toward the head by one
    logic push;  // write the feed value at the tail position
  } chain_cmd_t;

  // Per-cell control after tail decode.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ----- rtl/slid_cell.sv -----
// One storage cell of the list chain: holds one entry, takes its
// neighbor's entry on a shift or the feed value on a load. Uses slid_pkg.
module slid_cell (
  input  logic                       clk,
  input  slid_pkg::cell_ctl_t        ctl,
  input  logic [slid_pkg::VAL_W-1:0] feed,
  input  logic [slid_pkg::VAL_W-1:0] next_val,
  output logic [slid_pkg::VAL_W-1:0] val
);

  logic [slid_pkg::VAL_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= feed;
    end else if (ctl.shift) begin
      val_r <= next_val;
    end
  end

  assign val = val_r;

endmodule

// ----- rtl/slid_ctrl.sv -----
// Sequencer for the sorted list: decodes requests, circulates the list
// through the cell chain once per insert or delete request and registers the result.
// Uses slid_pkg.
module slid_ctrl #(
  parameter int CAPACITY = 32,
  parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [slid_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [slid_pkg::OUT_W-1:0]  out_tdata,
  input  logic [slid_pkg::VAL_W-1:0]  head,
  output slid_pkg::chain_cmd_t        cmd,
  output logic [LEN_W-1:0]            push_pos,
  output logic [slid_pkg::VAL_W-1:0]  feed,
  output logic [LEN_W-1:0]            occ
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                        state_r;
  logic [LEN_W-1:0]              occ_r, occ_nxt;
  logic [LEN_W-1:0]              rd_left_r;
  logic [LEN_W-1:0]              removed_r;
  logic                          need_push_r;
  logic                          is_ins_r;
  logic                          is_del_r;
  logic [slid_pkg::VAL_W-1:0]    val_r;
  logic [slid_pkg::STAT_W-1:0]   status_r;
  logic                          out_valid_r;
  logic [slid_pkg::OUT_W-1:0]    out_data_r;

  logic [slid_pkg::FUNC_W-1:0]   in_func;
  logic [slid_pkg::VAL_W-1:0]    in_value;
  logic                          in_ok;
  logic                          has_old, place, drop;
  logic [slid_pkg::VAL_W-1:0]    head_v;

  assign in_func  = in_tdata[1:0];
  assign in_value = in_tdata[15:2];
  assign in_ok    = (in_value >= slid_pkg::VALUE_MIN) && (in_value <= slid_pkg::VALUE_MAX);

  assign in_tready = (state_r == S_IDLE);

  // One step of the pass: look at the head entry and decide pop/push.
  assign has_old = (rd_left_r != '0);
  assign place   = is_ins_r && need_push_r && (val_r <= head);
  assign drop    = is_del_r && (head == val_r);

  always_comb begin
    cmd.pop  = 1'b0;
    cmd.push = 1'b0;
    feed     = val_r;
    if (state_r == S_RUN) begin
      if (has_old) begin
        cmd.pop  = !place;
        cmd.push = place || !drop;
        feed     = place ? val_r : head;
      end else begin
        cmd.push = need_push_r;
      end
    end
  end

  assign push_pos = occ_r - LEN_W'(cmd.pop);
  assign occ_nxt  = occ_r + LEN_W'(cmd.push) - LEN_W'(cmd.pop);
  assign head_v   = (occ_r != '0) ? head : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      rd_left_r   <= '0;
      need_push_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            val_r       <= in_value;
            status_r    <= slid_pkg::ST_DONE;
            removed_r   <= '0;
            is_ins_r    <= 1'b0;
            is_del_r    <= 1'b0;
            rd_left_r   <= '0;
            need_push_r <= 1'b0;
            state_r     <= S_RUN;
            if (in_func != slid_pkg::OP_UNUSED) begin
              priority if (!in_ok) begin
                status_r <= slid_pkg::ST_RANGE;
              end else if (in_func == slid_pkg::OP_DELETE) begin
                is_del_r  <= 1'b1;
                rd_left_r <= occ_r;
              end else if (occ_r == LEN_W'(CAPACITY)) begin
                status_r <= slid_pkg::ST_FULL;
              end else if (in_func == slid_pkg::OP_APPEND) begin
                need_push_r <= 1'b1;
              end else begin
                is_ins_r    <= 1'b1;
                need_push_r <= 1'b1;
                rd_left_r   <= occ_r;
              end
            end
          end
        end
        S_RUN: begin
          if (has_old) begin
            if (place) begin
              need_push_r <= 1'b0;
            end else begin
              rd_left_r <= rd_left_r - LEN_W'(1);
              if (drop) begin
                removed_r <= removed_r + LEN_W'(1);
              end
            end
          end else if (need_push_r) begin
            need_push_r <= 1'b0;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {4'b0, head_v, slid_pkg::CNT_W'(removed_r),
                            slid_pkg::CNT_W'(occ_r), status_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign occ        = occ_r;

endmodule

// ----- rtl/sorted_list_insert_delete.sv -----
// Sorted list with append, ordered insert and delete-all-equal.
// Requests arrive on the in_ stream (tdata: func[1:0], value[15:2]); one
// result per request leaves on the out_ stream (tdata: status[1:0],
// length[7:2], removed[13:8], head_value[27:14], zeros above).
// The list lives in a chain of CAPACITY cells, head in cell 0. An insert or
// a delete circulates the whole list once: at each step the chain shifts toward
// the head and the sequencer writes the head entry back at the tail (or drops
// it), or an insert writes its new value at the tail, in front of that entry,
// without a shift. An append writes the tail only. A request goes through its
// accept, a step per list entry for an insert or delete, one place step for an
// insert or the tail write for an append, a closing step and an output load;
// a rejected, full or unused one has only the accept, closing and output load.
// With a ready receiver the result is taken at the edge where the next request can be accepted.
// A new request is accepted once the sequencer is idle, even while the
// previous result still waits in the output register; a stalled receiver
// only holds the next result in the sequencer until the register drains.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; cell contents are not cleared, only the occupancy count.
// Uses slid_pkg, slid_cell, slid_ctrl and assert_macros.svh.
`include "assert_macros.svh"

module sorted_list_insert_delete #(
  parameter int CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [slid_pkg::IN_W-1:0]  in_tdata,   // func[1:0], value[15:2]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [slid_pkg::OUT_W-1:0] out_tdata   // status, length, removed, head_value
);

  localparam int LEN_W = $clog2(CAPACITY + 1);

  slid_pkg::chain_cmd_t       cmd;
  logic [LEN_W-1:0]           push_pos;
  logic [LEN_W-1:0]           occ;
  logic [slid_pkg::VAL_W-1:0] feed;
  logic [slid_pkg::VAL_W-1:0] cell_val [CAPACITY];

  slid_ctrl #(
    .CAPACITY (CAPACITY),
    .LEN_W    (LEN_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .head       (cell_val[0]),
    .cmd        (cmd),
    .push_pos   (push_pos),
    .feed       (feed),
    .occ        (occ)
  );

  // Build the chain: every cell shifts on a pop; the cell at the tail
  // position loads the feed value on a push.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slid_pkg::cell_ctl_t        ctl;
    logic [slid_pkg::VAL_W-1:0] nbr;

    assign ctl.shift = cmd.pop;
    assign ctl.load  = cmd.push && (push_pos == LEN_W'(i));

    if (i == CAPACITY - 1) begin : g_last
      assign nbr = feed;  // nothing beyond the last cell
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end

    slid_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .feed     (feed),
      .next_val (nbr),
      .val      (cell_val[i])
    );
  end

  // Occupancy never passes the chain length.
  `ASSERT_IMPLIES(a_occ_bound, clk, rst_n, 1'b1, occ <= LEN_W'(CAPACITY))
  // The chain stays untouched while waiting for a request.
  `ASSERT_IMPLIES(a_idle_quiet, clk, rst_n, in_tready, !cmd.push && !cmd.pop)
  // A request, once taken, keeps the next one from being accepted in the cycle after.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule
